### sv/assert_macros.svh
// Assertion macros for the RTL, included by mapped_byte_memory_bus.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, prop, msg)
`endif
`endif

### sv/mbmb_pkg.sv
package mbmb_pkg;

    localparam logic MODE_READ  = 1'b0;
    localparam logic MODE_WRITE = 1'b1;

    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_HALF = 2'd1;
    localparam logic [1:0] SIZE_WORD = 2'd2;

    typedef struct packed {
        logic        mode;
        logic [1:0]  size_code;
        logic [31:0] bus_address;
        logic [31:0] write_value;
    } req_t;

    typedef struct packed {
        logic [31:0] read_value;
        logic        bus_fault;
    } rsp_t;

    typedef struct packed {
        logic       en;
        logic       we;
        logic [7:0] data;
    } lane_cmd_t;

    // Number of bytes moved by one transaction; zero marks an invalid size.
    function automatic logic [2:0] size_bytes(input logic [1:0] size);
        logic [2:0] n;
        begin
            case (size)
                SIZE_BYTE: n = 3'd1;
                SIZE_HALF: n = 3'd2;
                SIZE_WORD: n = 3'd4;
                default:   n = 3'd0;
            endcase
            return n;
        end
    endfunction

endpackage

### sv/mbmb_bank.sv
module mbmb_bank
    import mbmb_pkg::*;
#(
    parameter int DEPTH = 16384,
    parameter int AW    = $clog2(DEPTH)
)
(
    input  logic            clk,
    input  lane_cmd_t       cmd,
    input  logic [AW-1:0]   addr,
    output logic [7:0]      rdata
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (cmd.en)
        begin
            if (cmd.we)
            begin
                mem[addr] <= cmd.data;
            end
            else
            begin
                rdata <= mem[addr];
            end
        end
    end

endmodule

### sv/mbmb_map.sv
module mbmb_map
    import mbmb_pkg::*;
#(
    parameter longint unsigned STORE_BYTES      = 65536,
    parameter longint unsigned FLASH_BYTES      = 32768,
    parameter longint unsigned SRAM_WINDOW_BASE = 536870912,
    parameter longint unsigned SRAM_BYTES       = 32768,
    parameter int              FLAT_W           = 16
)
(
    input  req_t              req,
    output logic              fault,
    output logic [FLAT_W-1:0] flat
);

    logic [32:0] addr_ext;
    logic [32:0] win_lo;
    logic [32:0] win_hi;
    logic [32:0] flat_ext;
    logic [32:0] last_ext;
    logic [2:0]  nbytes;
    logic        in_store;
    logic        in_win;

    always_comb
    begin
        nbytes   = size_bytes(req.size_code);
        addr_ext = {1'b0, req.bus_address};
        win_lo   = 33'(SRAM_WINDOW_BASE);
        win_hi   = win_lo + 33'(SRAM_BYTES);
        in_store = addr_ext < 33'(STORE_BYTES);
        in_win   = (addr_ext >= win_lo) && (addr_ext < win_hi);
        flat_ext = in_store ? addr_ext : 33'(FLASH_BYTES) + (addr_ext - win_lo);
        last_ext = flat_ext + 33'(nbytes);
        fault    = (nbytes == 3'd0) || !(in_store || in_win)
                   || (last_ext > 33'(STORE_BYTES));
        flat     = flat_ext[FLAT_W-1:0];
    end

endmodule

### sv/mapped_byte_memory_bus.sv
// The response is registered: an accepted transaction passes through ST_ISSUE, where the
// four byte-lane memories are accessed, and then ST_RESP, where rsp_valid is set. One transaction
// is handled at a time (req_ready is high only in ST_IDLE); response back pressure holds ST_RESP.
// Reset: rst_n is asynchronous and active low. After reset a clearing pass zeroes the
// store one row of four bytes per cycle, ceil(STORE_BYTES / 4) rows (16384 by default).
`include "assert_macros.svh"

module mapped_byte_memory_bus
    import mbmb_pkg::*;
#(
    parameter longint unsigned STORE_BYTES      = 65536,
    parameter longint unsigned FLASH_BYTES      = 32768,
    parameter longint unsigned SRAM_WINDOW_BASE = 536870912,
    parameter longint unsigned SRAM_BYTES       = 32768
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    localparam longint unsigned ROWS = (STORE_BYTES + 3) / 4;
    localparam int ROW_W  = $clog2(ROWS);
    localparam int FLAT_W = ROW_W + 2;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ISSUE,
        ST_RESP
    } state_t;

    state_t            state_reg, state_next;
    logic [ROW_W-1:0]  clr_row_reg, clr_row_next;
    logic              mode_reg, mode_next;
    logic [2:0]        nbytes_reg, nbytes_next;
    logic [1:0]        off_reg, off_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [31:0]       wdata_reg, wdata_next;
    logic              fault_reg, fault_next;
    logic              rsp_valid_reg, rsp_valid_next;
    rsp_t              rsp_reg, rsp_next;

    logic              map_fault;
    logic [FLAT_W-1:0] map_flat;
    lane_cmd_t         lane_cmd   [4];
    logic [ROW_W-1:0]  lane_addr  [4];
    logic [7:0]        lane_rdata [4];
    logic [3:0]        lane_en_vec;
    logic [31:0]       read_word;

    mbmb_map #(
        .STORE_BYTES      (STORE_BYTES),
        .FLASH_BYTES      (FLASH_BYTES),
        .SRAM_WINDOW_BASE (SRAM_WINDOW_BASE),
        .SRAM_BYTES       (SRAM_BYTES),
        .FLAT_W           (FLAT_W)
    ) u_map (
        .req   (req),
        .fault (map_fault),
        .flat  (map_flat)
    );

    for (genvar g = 0; g < 4; g++)
    begin : g_lane
        mbmb_bank #(
            .DEPTH (int'(ROWS)),
            .AW    (ROW_W)
        ) u_bank (
            .clk   (clk),
            .cmd   (lane_cmd[g]),
            .addr  (lane_addr[g]),
            .rdata (lane_rdata[g])
        );
        assign lane_en_vec[g] = lane_cmd[g].en;
    end

    // Lane L holds byte (L - offset) of the transaction; lanes below the offset use the next row.
    always_comb
    begin
        logic [1:0] k;
        logic [1:0] lane;
        for (int l = 0; l < 4; l++)
        begin
            k               = 2'(l) - off_reg;
            lane_cmd[l].en  = 1'b0;
            lane_cmd[l].we  = 1'b0;
            lane_cmd[l].data = wdata_reg[8*k +: 8];
            lane_addr[l]    = row_reg + ROW_W'(2'(l) < off_reg);
            if (state_reg == ST_CLEAR)
            begin
                lane_cmd[l].en   = 1'b1;
                lane_cmd[l].we   = 1'b1;
                lane_cmd[l].data = 8'd0;
                lane_addr[l]     = clr_row_reg;
            end
            else if (state_reg == ST_ISSUE)
            begin
                lane_cmd[l].en = !fault_reg && ({1'b0, k} < nbytes_reg);
                lane_cmd[l].we = (mode_reg == MODE_WRITE);
            end
        end
        for (int b = 0; b < 4; b++)
        begin
            lane = off_reg + 2'(b);
            read_word[8*b +: 8] = (3'(b) < nbytes_reg) ? lane_rdata[lane] : 8'd0;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_row_next   = clr_row_reg;
        mode_next      = mode_reg;
        nbytes_next    = nbytes_reg;
        off_next       = off_reg;
        row_next       = row_reg;
        wdata_next     = wdata_reg;
        fault_next     = fault_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                clr_row_next = clr_row_reg + ROW_W'(1);
                if (clr_row_reg == ROW_W'(ROWS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    mode_next   = req.mode;
                    nbytes_next = size_bytes(req.size_code);
                    off_next    = map_flat[1:0];
                    row_next    = map_flat[FLAT_W-1:2];
                    wdata_next  = req.write_value;
                    fault_next  = map_fault;
                    state_next  = ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next      = 1'b1;
                    rsp_next.bus_fault  = fault_reg;
                    rsp_next.read_value = (!fault_reg && mode_reg == MODE_READ)
                                          ? read_word : 32'd0;
                    state_next          = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_row_reg   <= '0;
            mode_reg      <= MODE_READ;
            nbytes_reg    <= '0;
            off_reg       <= '0;
            row_reg       <= '0;
            wdata_reg     <= '0;
            fault_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_row_reg   <= clr_row_next;
            mode_reg      <= mode_next;
            nbytes_reg    <= nbytes_next;
            off_reg       <= off_next;
            row_reg       <= row_next;
            wdata_reg     <= wdata_next;
            fault_reg     <= fault_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_reg       <= rsp_next;
        end
    end

    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `ASSERT_CLK(a_lane_en_state, clk, rst_n,
        (lane_en_vec != 4'd0) |-> (state_reg == ST_CLEAR || state_reg == ST_ISSUE),
        "memory lane enabled outside the clear pass or the issue cycle")
    `ASSERT_NEVER(a_fault_no_access, clk, rst_n,
        (state_reg == ST_ISSUE && fault_reg && lane_en_vec != 4'd0),
        "faulting transaction touched the store")
    `ASSERT_CLK(a_fault_zero_data, clk, rst_n,
        (rsp_valid_reg && rsp_reg.bus_fault) |-> (rsp_reg.read_value == 32'd0),
        "faulting response carries nonzero read data")
    `ASSERT_CLK(a_accept_to_issue, clk, rst_n,
        (req_valid && req_ready) |=> (state_reg == ST_ISSUE),
        "accepted transaction did not proceed to the memory access")

endmodule
